// ----- rtl/lfd_pkg.sv -----
// shared types and constants for the length-prefixed frame decoder
package lfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int FIELD_BYTES = WORD_W / BYTE_W;
    localparam int CNT_W       = $clog2(FIELD_BYTES);
    localparam int STATUS_W    = 3;
    localparam int PADDR_W     = 3;

    localparam logic [CNT_W-1:0] FIELD_LAST = CNT_W'(FIELD_BYTES - 1);

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // register select bit of paddr (word address)
    localparam int  REG_SEL_BIT   = 2;
    localparam logic REG_MAGIC    = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_MAGIC   = 3'd1,
        ST_BAD_MAGIC  = 3'd2,
        ST_NO_SIZE    = 3'd3,
        ST_INCOMPLETE = 3'd4,
        ST_MISMATCH   = 3'd5
    } status_t;

    typedef struct packed {
        logic              has_byte;
        logic [BYTE_W-1:0] data_byte;
        logic              frame_end;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        status_t           status;
    } result_t;

endpackage

// ----- rtl/lfd_apb_regs.sv -----
// apb register file holding the expected magic word
module lfd_apb_regs
    import lfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready,
    output logic [WORD_W-1:0]  magic_word
);

    logic [WORD_W-1:0] magic_reg;
    logic [WORD_W-1:0] magic_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        magic_next = magic_reg;
        if (wr_en && (paddr[REG_SEL_BIT] == REG_MAGIC)) begin
            magic_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg <= '0;
        end else begin
            magic_reg <= magic_next;
        end
    end

    assign prdata     = (paddr[REG_SEL_BIT] == REG_MAGIC) ? magic_reg : '0;
    assign magic_word = magic_reg;

endmodule

// ----- rtl/lfd_in_reg.sv -----
// input word register with ready derived from the downstream stage
module lfd_in_reg
    import lfd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  advance,
    output logic  in_valid,
    output item_t in_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign s_ready = !valid_reg || advance;
    assign take    = s_valid && s_ready;

    always_comb begin
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= s_item;
        end
    end

    assign in_valid = valid_reg;
    assign in_item  = item_reg;

endmodule

// ----- rtl/lfd_parser.sv -----
// frame parser state and per-word decode
module lfd_parser
    import lfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  item_t             item,
    input  logic [WORD_W-1:0] magic_word,
    output result_t           res
);

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_SIZE    = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CHECK   = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] sum_reg, sum_next;
    status_t           err_reg, err_next;
    logic [WORD_W-1:0] field_word;
    logic              field_last;
    logic              emit;
    status_t           end_status;

    assign field_word = {shift_reg[WORD_W-BYTE_W-1:0], item.data_byte};
    assign field_last = (cnt_reg == FIELD_LAST);

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        sum_next   = sum_reg;
        err_next   = err_reg;
        emit       = 1'b0;
        end_status = ST_OK;
        res        = '0;

        if (item.has_byte) begin
            unique case (phase_reg)
                PH_MAGIC: begin
                    shift_next = field_word;
                    cnt_next   = cnt_reg + 1'b1;
                    if (field_last) begin
                        shift_next = '0;
                        if (field_word != magic_word) begin
                            err_next   = ST_BAD_MAGIC;
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_SIZE;
                        end
                    end
                end
                PH_SIZE: begin
                    shift_next = field_word;
                    cnt_next   = cnt_reg + 1'b1;
                    if (field_last) begin
                        shift_next = '0;
                        rem_next   = field_word;
                        phase_next = (field_word == '0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    sum_next = sum_reg + WORD_W'(item.data_byte);
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == WORD_W'(1)) begin
                        phase_next = PH_CHECK;
                    end
                    emit = 1'b1;
                end
                PH_CHECK: begin
                    shift_next = field_word;
                    cnt_next   = cnt_reg + 1'b1;
                    if (field_last) begin
                        err_next   = (field_word == sum_reg) ? ST_OK : ST_MISMATCH;
                        phase_next = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        unique case (phase_next)
            PH_MAGIC:   end_status = ST_NO_MAGIC;
            PH_SIZE:    end_status = ST_NO_SIZE;
            PH_PAYLOAD: end_status = ST_INCOMPLETE;
            PH_CHECK:   end_status = ST_INCOMPLETE;
            default:    end_status = err_next;
        endcase

        if (item.frame_end) begin
            res.valid        = 1'b1;
            res.kind         = KIND_STATUS;
            res.payload_byte = '0;
            res.status       = end_status;
            phase_next       = PH_MAGIC;
            cnt_next         = '0;
            shift_next       = '0;
            rem_next         = '0;
            sum_next         = '0;
            err_next         = ST_OK;
        end else if (emit) begin
            res.valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = item.data_byte;
            res.status       = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC;
            cnt_reg   <= '0;
            shift_reg <= '0;
            rem_reg   <= '0;
            sum_reg   <= '0;
            err_reg   <= ST_OK;
        end else if (fire) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
            sum_reg   <= sum_next;
            err_reg   <= err_next;
        end
    end

    // a frame end always leaves a clean parser behind
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.frame_end |=> phase_reg == PH_MAGIC && sum_reg == '0 && cnt_reg == '0)
        else $error("parser not cleared after frame end");

    // payload bytes only come out of the payload phase
    a_payload_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.valid && res.kind == KIND_PAYLOAD |-> phase_reg == PH_PAYLOAD)
        else $error("payload byte outside payload phase");

    // in the payload phase there is always at least one byte still owed
    a_rem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> rem_reg != '0)
        else $error("payload phase with zero bytes remaining");

    // field byte counter only moves in the header and checksum phases
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !item.frame_end && (phase_reg == PH_PAYLOAD || phase_reg == PH_DONE)
        |=> $stable(cnt_reg))
        else $error("field counter moved outside a field");

endmodule

// ----- rtl/lfd_out_reg.sv -----
// result register toward the output channel
module lfd_out_reg
    import lfd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res,
    input  logic    m_ready,
    output logic    advance,
    output logic    m_valid,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // the register frees up when empty or when the receiver takes the word
    assign advance = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = load && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && load && res.valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ----- rtl/length_frame_decoder.sv -----
// top level of the length-prefixed frame decoder
//
// input channel (s_*): one raw frame byte per word, valid/ready handshake;
//   s_has_byte low makes an empty word, s_frame_end marks the last word
// output channel (m_*): at most one word out per input word; m_kind low
//   carries a payload byte, m_kind high carries the final frame status
// frame layout: magic word, payload length, payload, checksum, each
//   32-bit field big-endian; the checksum is the wrapping byte sum
// apb port: one register, the expected magic word at address 0
// path: an accepted input word waits in the input register, is decoded
//   combinationally, and its result is loaded into the result register
// throughput: one word per cycle unless the receiver stalls; the decode is
//   a single compare, add and counter update between the input and result registers
// receiver stall: the result register holds, the input register fills,
//   and s_ready drops once both are occupied
// reset: the parser returns to the magic field, the checksum and counts
//   clear, both stage registers empty and the magic word resets to zero
// a frame end word always yields a status and readies the next frame
module length_frame_decoder
    import lfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_has_byte,
    input  logic [BYTE_W-1:0]  s_data_byte,
    input  logic               s_frame_end,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [BYTE_W-1:0]  m_payload_byte,
    output logic [STATUS_W-1:0] m_status
);

    logic [WORD_W-1:0] magic_word;
    item_t             s_item;
    item_t             in_item;
    logic              in_valid;
    logic              advance;
    logic              fire;
    result_t           res;
    result_t           m_res;

    assign s_item.has_byte  = s_has_byte;
    assign s_item.data_byte = s_data_byte;
    assign s_item.frame_end = s_frame_end;

    lfd_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .magic_word (magic_word)
    );

    lfd_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .advance  (advance),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    // a buffered word is decoded when the result register can take its output
    assign fire = in_valid && advance;

    lfd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (in_item),
        .magic_word (magic_word),
        .res        (res)
    );

    lfd_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (fire),
        .res     (res),
        .m_ready (m_ready),
        .advance (advance),
        .m_valid (m_valid),
        .m_res   (m_res)
    );

    assign m_kind         = m_res.kind;
    assign m_payload_byte = m_res.payload_byte;
    assign m_status       = m_res.status;

endmodule

// ----- bench/tb.sv -----
// self-checking bench for the length-prefixed frame decoder with a built-in frame predictor
module tb
    import lfd_pkg::*;
();

    localparam logic [PADDR_W-1:0] MAGIC_ADDR = '0;
    localparam int unsigned RANDOM_ITEMS   = 1750;
    localparam int unsigned RANDOM_PHASES  = 4;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    // clock, reset and the two ports of the block
    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [WORD_W-1:0]   pwdata      = '0;
    logic [WORD_W-1:0]   prdata;
    logic                pready;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic                s_has_byte  = 1'b0;
    logic [BYTE_W-1:0]   s_data_byte = '0;
    logic                s_frame_end = 1'b0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic                m_kind;
    logic [BYTE_W-1:0]   m_payload_byte;
    logic [STATUS_W-1:0] m_status;

    length_frame_decoder u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_has_byte     (s_has_byte),
        .s_data_byte    (s_data_byte),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .m_status       (m_status)
    );

    // clock with period 2
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // parser position inside a frame
    typedef enum logic [2:0] {
        P_MAGIC   = 3'd0,
        P_SIZE    = 3'd1,
        P_PAYLOAD = 3'd2,
        P_CHECK   = 3'd3,
        P_DONE    = 3'd4
    } parse_phase_t;

    // one word expected on the result side
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        status_t           status;
    } decoded_t;

    // words waiting to be driven, and decoded words waiting to come out
    item_t    frame_words_q[$];
    decoded_t decoded_q[$];
    // raw bytes of the frame being built
    logic [BYTE_W-1:0] frame_bytes[$];

    // shadow of the magic register and of the parser state
    logic [WORD_W-1:0] magic_reg = '0;
    parse_phase_t      dec_phase = P_MAGIC;
    logic [CNT_W-1:0]  dec_cnt   = '0;
    logic [WORD_W-1:0] dec_shift = '0;
    logic [WORD_W-1:0] dec_left  = '0;
    logic [WORD_W-1:0] dec_sum   = '0;
    status_t           dec_err   = ST_OK;

    int unsigned n_items        = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles   = 0;
    int unsigned tx_gap         = 0;
    int unsigned rx_gap         = 0;
    bit          tx_calm        = 1'b0;
    bit          rx_calm        = 1'b0;
    bit          s_taken        = 1'b0;

    // shift one byte into the current 32-bit field, high when the field is full
    function automatic bit take_field_byte(logic [BYTE_W-1:0] b);
        dec_shift = {dec_shift[WORD_W-BYTE_W-1:0], b};
        if (dec_cnt == FIELD_LAST) begin
            dec_cnt = '0;
            return 1'b1;
        end
        dec_cnt = dec_cnt + 1'b1;
        return 1'b0;
    endfunction

    // advance the parser by one accepted word and queue what it should produce
    function automatic void decode_word(item_t w);
        decoded_t r;
        bit       emit;
        emit = 1'b0;
        if (w.has_byte) begin
            case (dec_phase)
                P_MAGIC: if (take_field_byte(w.data_byte)) begin
                    if (dec_shift != magic_reg) begin
                        dec_err   = ST_BAD_MAGIC;
                        dec_phase = P_DONE;
                    end else begin
                        dec_phase = P_SIZE;
                    end
                    dec_shift = '0;
                end
                P_SIZE: if (take_field_byte(w.data_byte)) begin
                    dec_left  = dec_shift;
                    dec_shift = '0;
                    dec_phase = (dec_left == '0) ? P_CHECK : P_PAYLOAD;
                end
                P_PAYLOAD: begin
                    dec_sum  = dec_sum + w.data_byte;
                    dec_left = dec_left - 1'b1;
                    if (dec_left == '0)
                        dec_phase = P_CHECK;
                    emit = 1'b1;
                end
                P_CHECK: if (take_field_byte(w.data_byte)) begin
                    dec_err   = (dec_shift == dec_sum) ? ST_OK : ST_MISMATCH;
                    dec_phase = P_DONE;
                end
                default: ;
            endcase
        end
        if (w.frame_end) begin
            // frame end wins over a payload byte in the same word
            r.kind         = KIND_STATUS;
            r.payload_byte = '0;
            case (dec_phase)
                P_MAGIC:            r.status = ST_NO_MAGIC;
                P_SIZE:             r.status = ST_NO_SIZE;
                P_PAYLOAD, P_CHECK: r.status = ST_INCOMPLETE;
                default:            r.status = dec_err;
            endcase
            decoded_q = {decoded_q, r};
            dec_phase = P_MAGIC;
            dec_cnt   = '0;
            dec_shift = '0;
            dec_left  = '0;
            dec_sum   = '0;
            dec_err   = ST_OK;
        end else if (emit) begin
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = w.data_byte;
            r.status       = ST_OK;
            decoded_q = {decoded_q, r};
        end
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic void push_word(bit has, logic [BYTE_W-1:0] b, bit fend);
        item_t w;
        w.has_byte  = has;
        w.data_byte = b;
        w.frame_end = fend;
        frame_words_q = {frame_words_q, w};
        n_items++;
    endfunction

    // big-endian 32-bit field as four byte words
    function automatic void push_field(logic [WORD_W-1:0] v);
        for (int i = FIELD_BYTES - 1; i >= 0; i--)
            push_word(1'b1, v[i*BYTE_W +: BYTE_W], 1'b0);
    endfunction

    function automatic void add_field(logic [WORD_W-1:0] v);
        for (int i = FIELD_BYTES - 1; i >= 0; i--)
            frame_bytes = {frame_bytes, v[i*BYTE_W +: BYTE_W]};
    endfunction

    // magic, size, body_n payload bytes, checksum (optionally corrupted), tail bytes
    function automatic void build_frame(logic [WORD_W-1:0] magic, logic [WORD_W-1:0] len,
                                        int unsigned body_n, bit bad_sum,
                                        int unsigned tail);
        logic [WORD_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        frame_bytes.delete();
        sum = '0;
        add_field(magic);
        add_field(len);
        repeat (body_n) begin
            b   = BYTE_W'($urandom);
            sum = sum + b;
            frame_bytes = {frame_bytes, b};
        end
        if (bad_sum)
            sum = sum ^ (32'd1 << $urandom_range(WORD_W - 1));
        add_field(sum);
        repeat (tail)
            frame_bytes = {frame_bytes, BYTE_W'($urandom)};
    endfunction

    // first cut bytes of the frame, with empty words mixed in, then the frame end (on the last byte or in its own word)
    function automatic void send_frame(int unsigned cut, bit end_on_byte,
                                       int unsigned empty_pct);
        for (int unsigned i = 0; i < cut; i++) begin
            while ($urandom_range(99) < empty_pct)
                push_word(1'b0, BYTE_W'($urandom), 1'b0);
            push_word(1'b1, frame_bytes[i], end_on_byte && (i == cut - 1));
        end
        if (!end_on_byte || cut == 0)
            push_word(1'b0, BYTE_W'($urandom), 1'b1);
    endfunction

    // mostly well-formed frames with random content, some broken ones and line noise
    function automatic void random_frame();
        logic [WORD_W-1:0] mgc;
        logic [WORD_W-1:0] len;
        int unsigned       body_n;
        int unsigned       cut;
        int unsigned       r;
        r = $urandom_range(99);
        if (r < 6) begin
            repeat ($urandom_range(8, 1))
                push_word(1'($urandom), BYTE_W'($urandom), $urandom_range(7) == 0);
            return;
        end
        mgc = magic_reg;
        if (r < 10)
            mgc = magic_reg ^ (32'd1 << $urandom_range(WORD_W - 1));
        else if (r < 14)
            mgc = $urandom;
        len = $urandom_range(12);
        if ($urandom_range(9) == 0)
            len = $urandom_range(80, 13);
        body_n = len;
        if ($urandom_range(39) == 0) begin
            // declared size far beyond what is sent
            len    = $urandom | 32'h0100_0000;
            body_n = $urandom_range(10);
        end
        build_frame(mgc, len, body_n, $urandom_range(99) < 12,
                    ($urandom_range(99) < 15) ? $urandom_range(5, 1) : 0);
        cut = frame_bytes.size();
        if ($urandom_range(99) < 15)
            cut = $urandom_range(frame_bytes.size() - 1);
        send_frame(cut, 1'($urandom_range(1)), ($urandom_range(3) == 0) ? 25 : 0);
    endfunction

    // register write: setup cycle, then access cycle
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (addr == MAGIC_ADDR)
            magic_reg = data;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold until every word is sent and every decoded word has come out
    task automatic wait_idle();
        while (frame_words_q.size() != 0 || s_valid || decoded_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES)
            @(posedge aclk);
    endtask

    // input driver: next word at the falling edge once the current one is taken
    always @(negedge aclk) begin
        item_t w;
        if (!s_valid || s_taken) begin
            if (tx_gap != 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (frame_words_q.size() != 0) begin
                w = frame_words_q.pop_front();
                s_valid     <= 1'b1;
                s_has_byte  <= w.has_byte;
                s_data_byte <= w.data_byte;
                s_frame_end <= w.frame_end;
                tx_gap = pick_gap(tx_calm);
                // switch in and out of stretches with no gaps
                if ($urandom_range(199) == 0)
                    tx_calm = !tx_calm;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (rx_gap != 0) begin
            rx_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            rx_gap = pick_gap(rx_calm);
            if ($urandom_range(299) == 0)
                rx_calm = !rx_calm;
        end
    end

    // sample both handshakes at the rising edge: predict, check, watch for a hang
    always @(posedge aclk) begin
        item_t    w;
        decoded_t e;
        s_taken = aresetn && s_valid && s_ready;
        if (s_taken) begin
            w.has_byte  = s_has_byte;
            w.data_byte = s_data_byte;
            w.frame_end = s_frame_end;
            decode_word(w);
        end
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                $error("result word with nothing expected: kind %0d payload_byte %0h status %0d",
                       m_kind, m_payload_byte, m_status);
                mismatch_count++;
            end else begin
                e = decoded_q.pop_front();
                if (m_kind !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, m_kind);
                    mismatch_count++;
                end
                if (m_payload_byte !== e.payload_byte) begin
                    $error("payload_byte: expected %0h, got %0h", e.payload_byte,
                           m_payload_byte);
                    mismatch_count++;
                end
                if (m_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_status);
                    mismatch_count++;
                end
            end
        end
        if (s_taken || (aresetn && m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int unsigned       target;
        logic [WORD_W-1:0] mval;
        repeat (9)
            @(negedge aclk);
        aresetn <= 1'b1;

        // directed frames with an all-ones magic word
        apb_write(MAGIC_ADDR, '1);
        // end marker alone: no magic seen
        push_word(1'b0, 8'h00, 1'b1);
        // wrong magic, later byte with the end flag is ignored
        push_field('0);
        push_word(1'b1, 8'hFF, 1'b1);
        // zero length, zero checksum, an empty word inside, a trailing byte
        push_field('1);
        push_word(1'b0, 8'hC3, 1'b0);
        push_field('0);
        push_field('0);
        push_word(1'b1, 8'h5A, 1'b0);
        push_word(1'b0, 8'h00, 1'b1);
        // maximum length, early end on a payload byte that is then not passed on
        push_field('1);
        push_field('1);
        push_word(1'b1, 8'h00, 1'b0);
        push_word(1'b1, 8'hFF, 1'b1);
        wait_idle();

        // random phases, each under its own magic word
        for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       mval = '0;
                1:       mval = '1;
                default: mval = $urandom;
            endcase
            apb_write(MAGIC_ADDR, mval);
            target = n_items + RANDOM_ITEMS / RANDOM_PHASES;
            while (n_items < target)
                random_frame();
            // sender stops here until every decoded word is back
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
